// File: rtl/core/nntb_pkg.sv
// ----------------------------------------------------------------------------
// nntb_pkg
// Shared types and constants of the nearest-neighbour tour builder.
// ----------------------------------------------------------------------------
`default_nettype none

package nntb_pkg;

  localparam int CITY_W  = 6;
  localparam int COUNT_W = 7;
  localparam int IN_DW   = 32;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_BUILD = 1'b1;

  localparam logic REG_CITY_COUNT = 1'b0;

  localparam logic [COUNT_W-1:0] MIN_CITIES   = 7'd2;
  localparam logic [COUNT_W-1:0] COUNT_RESET  = 7'd64;

  typedef struct packed {
    logic              mem_wr;
    logic              init;
    logic              rd;
    logic              emit;
    logic              last;
    logic [CITY_W-1:0] col;
    logic [CITY_W-1:0] pos;
    logic [CITY_W-1:0] start;
  } nntb_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic found;
  } nntb_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/nearest_neighbor_tour_builder.sv
// Write word: stored in the distance memory on acceptance, no result.
// Build word: after acceptance the start state waits for a free output slot,
// then registers the start city; each further city follows a scan of all n
// columns of the current row (n = clamped city count) and a free slot.
// One build at a time; the input is held off until the tour's last word is
// registered. Reset: idle, visited marks clear, city_count 64, memory as is.
`default_nettype none

// ----------------------------------------------------------------------------
// nearest_neighbor_tour_builder
// Greedy nearest-neighbour tour over a loaded distance matrix.
// ----------------------------------------------------------------------------
module nearest_neighbor_tour_builder import nntb_pkg::*; #(
  parameter int MAX_CITIES = 64,
  parameter int DIST_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // from_city, to_city, distance, pad
  input  wire logic        s_tuser,   // opcode
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // tour_city, tour_position, pad
  output logic             m_tlast,   // last_city
  output logic             m_tuser,   // no_path
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [COUNT_W-1:0] city_count;
  logic               reg_idx;
  nntb_cmd_t          cmd;
  nntb_stat_t         st;
  logic [CITY_W-1:0]  tour_city;
  logic [CITY_W-1:0]  tour_position;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      city_count <= COUNT_RESET;
    end else if (psel && penable && pwrite && pready && (reg_idx == REG_CITY_COUNT)) begin
      city_count <= pwdata[COUNT_W-1:0];
    end
  end

  assign prdata = (reg_idx == REG_CITY_COUNT) ? 32'(city_count) : '0;

  nntb_ctrl #(
    .MAX_CITIES (MAX_CITIES)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .opcode     (s_tuser),
    .from_city  (s_tdata[5:0]),
    .city_count (city_count),
    .cmd        (cmd),
    .st         (st)
  );

  nntb_dpath #(
    .MAX_CITIES (MAX_CITIES),
    .DIST_WIDTH (DIST_WIDTH)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .from_city     (s_tdata[5:0]),
    .to_city       (s_tdata[11:6]),
    .distance      (s_tdata[43:12]),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .tour_city     (tour_city),
    .tour_position (tour_position),
    .last_city     (m_tlast),
    .no_path       (m_tuser)
  );

  assign m_tdata = {4'b0, tour_position, tour_city};

endmodule

`default_nettype wire

// File: rtl/core/nntb_ctrl.sv
// ----------------------------------------------------------------------------
// nntb_ctrl
// Sequencer: takes input words, clamps count and start city, steps the
// row scan column by column and tour position by position.
// ----------------------------------------------------------------------------
`default_nettype none

module nntb_ctrl import nntb_pkg::*; #(
  parameter int MAX_CITIES = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic               opcode,
  input  wire logic [CITY_W-1:0]  from_city,
  input  wire logic [COUNT_W-1:0] city_count,
  output nntb_cmd_t               cmd,
  input  wire nntb_stat_t         st
);

  localparam int CW = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_START = 5'b00010,
    S_SCAN  = 5'b00100,
    S_DRAIN = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t state, state_next;
  logic [CW-1:0] col, col_next;
  logic [CW-1:0] pos, pos_next;
  logic [CW-1:0] n_m1, n_m1_next;
  logic [CW-1:0] start, start_next;
  logic [COUNT_W-1:0] n_clamp;
  logic accept;
  logic step_last;

  always_comb begin
    priority if (city_count < MIN_CITIES) begin
      n_clamp = MIN_CITIES;
    end else if (city_count > COUNT_W'(MAX_CITIES)) begin
      n_clamp = COUNT_W'(MAX_CITIES);
    end else begin
      n_clamp = city_count;
    end
  end

  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign step_last = !st.found || (pos == n_m1);

  always_comb begin
    state_next = state;
    col_next   = col;
    pos_next   = pos;
    n_m1_next  = n_m1;
    start_next = start;
    cmd        = '0;
    cmd.col    = CITY_W'(col);
    cmd.pos    = CITY_W'(pos);
    cmd.start  = CITY_W'(start);
    cmd.last   = step_last;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (opcode == OP_BUILD) begin
            n_m1_next = CW'(n_clamp - 7'd1);
            if ({1'b0, from_city} >= n_clamp) begin
              start_next = CW'(n_clamp - 7'd1);
            end else begin
              start_next = from_city[CW-1:0];
            end
            state_next = S_START;
          end else begin
            cmd.mem_wr = 1'b1;
          end
        end
      end
      S_START: begin
        if (st.slot_free) begin
          cmd.init   = 1'b1;
          pos_next   = CW'(1);
          col_next   = '0;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.rd   = 1'b1;
        col_next = col + CW'(1);
        if (col == n_m1) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (st.slot_free) begin
          cmd.emit = 1'b1;
          if (step_last) begin
            state_next = S_IDLE;
          end else begin
            pos_next   = pos + CW'(1);
            col_next   = '0;
            state_next = S_SCAN;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      col   <= '0;
      pos   <= '0;
      n_m1  <= '0;
      start <= '0;
    end else begin
      state <= state_next;
      col   <= col_next;
      pos   <= pos_next;
      n_m1  <= n_m1_next;
      start <= start_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/nntb_dpath.sv
// ----------------------------------------------------------------------------
// nntb_dpath
// Distance memory, visited marks, running minimum over a row and the
// output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module nntb_dpath import nntb_pkg::*; #(
  parameter int MAX_CITIES = 64,
  parameter int DIST_WIDTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire nntb_cmd_t         cmd,
  output nntb_stat_t             st,
  input  wire logic [CITY_W-1:0] from_city,
  input  wire logic [CITY_W-1:0] to_city,
  input  wire logic [IN_DW-1:0]  distance,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [CITY_W-1:0]      tour_city,
  output logic [CITY_W-1:0]      tour_position,
  output logic                   last_city,
  output logic                   no_path
);

  localparam int CW    = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
  localparam int DEPTH = 1 << (2 * CW);
  localparam int XW    = (DIST_WIDTH > IN_DW) ? DIST_WIDTH : IN_DW;

  logic [DIST_WIDTH-1:0] mem [DEPTH];
  logic [DIST_WIDTH-1:0] rdata;
  logic [XW-1:0]         dist_x;
  logic                  wr_ok;
  logic                  rd_valid;
  logic [CW-1:0]         rd_col;
  logic [MAX_CITIES-1:0] visited;
  logic [CW-1:0]         cur_city;
  logic [CW-1:0]         best_city;
  logic [DIST_WIDTH-1:0] best;
  logic                  found;
  logic                  take;
  logic                  load;

  assign dist_x = XW'(distance);
  assign wr_ok  = cmd.mem_wr && ({1'b0, from_city} < COUNT_W'(MAX_CITIES))
                  && ({1'b0, to_city} < COUNT_W'(MAX_CITIES));

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[{from_city[CW-1:0], to_city[CW-1:0]}] <= dist_x[DIST_WIDTH-1:0];
    end
    if (cmd.rd) begin
      rdata <= mem[{cur_city, cmd.col[CW-1:0]}];
    end
  end

  // compare stage, one column behind the read
  assign take = rd_valid && (rdata != '0) && !visited[rd_col]
                && (!found || (rdata < best));

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      found    <= 1'b0;
      visited  <= '0;
      cur_city <= '0;
    end else begin
      rd_valid <= cmd.rd;
      if (cmd.init) begin
        visited  <= {{(MAX_CITIES-1){1'b0}}, 1'b1} << cmd.start[CW-1:0];
        cur_city <= cmd.start[CW-1:0];
        found    <= 1'b0;
      end else if (cmd.emit) begin
        found <= 1'b0;
        if (found) begin
          visited[best_city] <= 1'b1;
          cur_city           <= best_city;
        end
      end else if (take) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_col <= cmd.col[CW-1:0];
    if (take) begin
      best      <= rdata;
      best_city <= rd_col;
    end
  end

  assign load = cmd.init || cmd.emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      tour_city     <= cmd.start;
      tour_position <= '0;
      last_city     <= 1'b0;
      no_path       <= 1'b0;
    end else if (cmd.emit) begin
      tour_city     <= found ? CITY_W'(best_city) : '0;
      tour_position <= cmd.pos;
      last_city     <= cmd.last;
      no_path       <= !found;
    end
  end

  assign st.slot_free = !m_tvalid || m_tready;
  assign st.found     = found;

endmodule

`default_nettype wire

// File: rtl/core/nntb_check.sv
// ----------------------------------------------------------------------------
// nntb_check
// Port-level checks of the tour builder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module nntb_check (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata,
  input wire logic        m_tlast,
  input wire logic        m_tuser
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser))
    else $error("output word changed under stall");

  // no path always ends the tour
  a_nopath_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("no_path without last");

  // the start city is never the last of a tour
  a_start_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[11:6] == 6'd0) |-> !m_tlast && !m_tuser)
    else $error("position 0 flagged last");

  // a build holds off the input
  a_build_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser |=> !s_tready)
    else $error("input taken during build");

endmodule

bind nearest_neighbor_tour_builder nntb_check u_nntb_check (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

`default_nettype wire
